>>> design/wbss_pkg.sv
// wbss_pkg: shared types, constants and signature helpers for the byte signature scanner
// no dependencies; compiled first, used by the channel interfaces and every module
package wbss_pkg;

  // configuration port geometry
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int ADDR_W      = 64;
  localparam int POS_W       = 32;
  localparam int DISP_W      = 32;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SIG_LOW   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIG_HIGH  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WILD_MASK = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SIG_LEN   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REL_SIZE  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDR = 3'd5;

  // smallest relative size that resolves a displacement
  localparam int REL_MIN = 4;

  typedef logic [7:0] byte_t;

  // configuration register file
  typedef struct packed {
    logic [63:0]       sig_low;
    logic [63:0]       sig_high;
    logic [15:0]       wild_mask;
    logic [4:0]        sig_len;
    logic [5:0]        rel_size;
    logic [ADDR_W-1:0] base_addr;
  } cfg_t;

  // evaluation status from the compare stage to the window stage
  typedef struct packed {
    logic pending;  // a byte waits for evaluation
    logic emit;     // that evaluation produces a result
    logic stall;    // result cannot move on yet
  } eval_ctl_t;

  // partial result between compare and resolve stages
  typedef struct packed {
    logic              found;
    logic [POS_W:0]    offset;  // alignment plus relative size
    logic [DISP_W-1:0] disp;
  } res_t;

  // signature byte k; bytes past the sixteenth read as zero
  function automatic byte_t sig_byte(cfg_t c, int unsigned k);
    if (k < 8) begin
      return c.sig_low[{k[2:0], 3'b000} +: 8];
    end else if (k < 16) begin
      return c.sig_high[{k[2:0], 3'b000} +: 8];
    end
    return 8'h00;
  endfunction

  // wildcard bit of signature byte k; none past the sixteenth
  function automatic logic sig_wild(cfg_t c, int unsigned k);
    if (k < 16) begin
      return c.wild_mask[k[3:0]];
    end
    return 1'b0;
  endfunction

endpackage

>>> design/wbss_channels.sv
// wbss_in_if / wbss_out_if: valid/ready channels for scanned bytes and scan results
// depends on wbss_pkg
interface wbss_in_if;
  import wbss_pkg::*;
  logic  valid;
  logic  ready;
  byte_t scan_byte;
  logic  first_byte;
  logic  last_byte;
  modport source(output valid, scan_byte, first_byte, last_byte, input ready);
  modport sink(input valid, scan_byte, first_byte, last_byte, output ready);
endinterface

interface wbss_out_if;
  import wbss_pkg::*;
  logic              valid;
  logic              ready;
  logic              found;
  logic [ADDR_W-1:0] match_address;
  modport source(output valid, found, match_address, input ready);
  modport sink(input valid, found, match_address, output ready);
endinterface

>>> design/wbss_window.sv
// wbss_window: byte shift line, byte counter, done flag and evaluation request
// depends on wbss_pkg; fed by the input channel, steered by wbss_match status
module wbss_window #(
  parameter int WINDOW_BYTES = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic                     first,
  input  logic                     last,
  input  wbss_pkg::byte_t          data,
  input  wbss_pkg::eval_ctl_t      ctl,
  output wbss_pkg::byte_t          window [WINDOW_BYTES],
  output logic [wbss_pkg::POS_W-1:0] pos,
  output logic                     pending,
  output logic                     last_q,
  output logic                     scan_done
);
  import wbss_pkg::*;

  logic done_eff;
  logic take;

  // the byte under evaluation may finish the scan in this very cycle
  assign done_eff = scan_done | (pending & ctl.emit);
  assign take     = accept & (first | ~done_eff);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      pending   <= 1'b0;
      scan_done <= 1'b0;
    end else if (accept) begin
      if (take) begin
        pos       <= first ? POS_W'(1) : pos + POS_W'(1);
        pending   <= 1'b1;
        scan_done <= 1'b0;
      end else begin
        pending   <= 1'b0;
        scan_done <= 1'b1;
      end
    end else if (pending && !ctl.stall) begin
      pending   <= 1'b0;
      scan_done <= scan_done | ctl.emit;
    end
  end

  // shift line, entry 0 newest; entries beyond the count are never read
  always_ff @(posedge clk) begin
    if (take) begin
      window[0] <= data;
      for (int i = 1; i < WINDOW_BYTES; i++) begin
        window[i] <= window[i-1];
      end
      last_q <= last;
    end
  end

endmodule

>>> design/wbss_match.sv
// wbss_match: parallel wildcard compare over all alignments, pick, displacement fetch
// depends on wbss_pkg; reads wbss_window state, feeds wbss_resolve
module wbss_match #(
  parameter int MAX_SIGNATURE = 16,
  parameter int WINDOW_BYTES  = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  wbss_pkg::cfg_t             cfg,
  input  wbss_pkg::byte_t            window [WINDOW_BYTES],
  input  logic [wbss_pkg::POS_W-1:0] pos,
  input  logic                       pending,
  input  logic                       last_q,
  input  logic                       take,
  output wbss_pkg::eval_ctl_t        ctl,
  output logic                       res_valid,
  output wbss_pkg::res_t             res
);
  import wbss_pkg::*;

  localparam int SPAN_MAX = (MAX_SIGNATURE > WINDOW_BYTES) ? MAX_SIGNATURE : WINDOW_BYTES;
  localparam int JW       = $clog2(SPAN_MAX + 1);
  localparam int IW       = $clog2(SPAN_MAX);

  byte_t               wz [SPAN_MAX];
  logic [JW-1:0]       len_c;
  logic [JW-1:0]       rel_c;
  logic [JW-1:0]       span;
  logic [SPAN_MAX:1]   cand;
  logic [SPAN_MAX:1]   hit;
  logic [JW-1:0]       sel;
  logic                any_hit;
  logic [POS_W-1:0]    align;
  logic [DISP_W-1:0]   disp;
  logic [JW+1:0]       dhi [4];
  logic [JW+1:0]       dix [4];
  logic                s2_ready;
  logic                fire;

  // window padded with zeros out to the longest span
  for (genvar p = 0; p < SPAN_MAX; p++) begin : g_pad
    if (p < WINDOW_BYTES) begin : g_win
      assign wz[p] = window[p];
    end else begin : g_zero
      assign wz[p] = '0;
    end
  end

  // clamp length and relative size, span is the larger
  always_comb begin
    if (cfg.sig_len == '0) begin
      len_c = JW'(1);
    end else if (32'(cfg.sig_len) > MAX_SIGNATURE) begin
      len_c = JW'(MAX_SIGNATURE);
    end else begin
      len_c = JW'(cfg.sig_len);
    end
    if (32'(cfg.rel_size) < REL_MIN) begin
      rel_c = '0;
    end else if (32'(cfg.rel_size) > WINDOW_BYTES) begin
      rel_c = JW'(WINDOW_BYTES);
    end else begin
      rel_c = JW'(cfg.rel_size);
    end
    span = (rel_c > len_c) ? rel_c : len_c;
  end

  // one comparator row per tail distance j (alignment = count - j)
  for (genvar j = 1; j <= SPAN_MAX; j++) begin : g_align
    logic [MAX_SIGNATURE-1:0] kok;
    for (genvar k = 0; k < MAX_SIGNATURE; k++) begin : g_byte
      if (j - 1 - k >= 0) begin : g_cmp
        assign kok[k] = (JW'(k) >= len_c) || sig_wild(cfg, k) ||
                        (wz[j-1-k] == sig_byte(cfg, k));
      end else begin : g_out
        assign kok[k] = 1'b1;
      end
    end
    // at a normal byte only the span alignment; at the last byte the tail too
    assign cand[j] = (JW'(j) >= len_c) && (JW'(j) <= span) && (pos >= POS_W'(j)) &&
                     (last_q || (JW'(j) == span));
    assign hit[j]  = cand[j] & (&kok);
  end

  // earliest alignment wins: largest tail distance
  always_comb begin
    sel = '0;
    for (int j = 1; j <= SPAN_MAX; j++) begin
      if (hit[j]) begin
        sel = JW'(j);
      end
    end
  end
  assign any_hit = |hit;
  assign align   = pos - POS_W'(sel);

  // little-endian displacement; bytes beyond the image read as zero
  always_comb begin
    disp = '0;
    for (int i = 0; i < 4; i++) begin
      dhi[i] = {2'b00, sel} + (JW+2)'(3 - i);
      dix[i] = dhi[i] - {2'b00, rel_c};
      if (rel_c != '0 && dhi[i] >= {2'b00, rel_c}) begin
        disp[8*i +: 8] = wz[dix[i][IW-1:0]];
      end
    end
  end

  // handshake towards the window stage
  assign s2_ready    = ~res_valid | take;
  assign ctl.pending = pending;
  assign ctl.emit    = pending & (any_hit | last_q);
  assign ctl.stall   = ctl.emit & ~s2_ready;
  assign fire        = ctl.emit & s2_ready;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res.found  <= any_hit;
      res.offset <= any_hit ? ({1'b0, align} + (POS_W+1)'(rel_c)) : '0;
      res.disp   <= any_hit ? disp : '0;
    end
  end

endmodule

>>> design/wbss_resolve.sv
// wbss_resolve: final address add and output register of the result channel
// depends on wbss_pkg and wbss_out_if; fed by wbss_match
module wbss_resolve (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [wbss_pkg::ADDR_W-1:0] base_addr,
  input  logic                        res_valid,
  input  wbss_pkg::res_t              res,
  output logic                        take,
  wbss_out_if.source                  result_out
);
  import wbss_pkg::*;

  logic [ADDR_W-1:0] target;

  // base + alignment + relative size + sign-extended displacement
  assign target = base_addr + ADDR_W'(res.offset) +
                  {{(ADDR_W-DISP_W){res.disp[DISP_W-1]}}, res.disp};
  assign take   = ~result_out.valid | result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (take) begin
      result_out.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      result_out.found         <= res.found;
      result_out.match_address <= res.found ? target : '0;
    end
  end

endmodule

>>> design/wildcard_byte_signature_scanner_core.sv
// wildcard_byte_signature_scanner_core: top level, configuration registers and stage wiring
// depends on wbss_pkg, wbss_channels, wbss_window, wbss_match, wbss_resolve
//
//  port        | dir | transfer                                | contents
//  ------------+-----+-----------------------------------------+---------------------------------
//  scan_in     | in  | valid & ready                           | scan_byte, first_byte, last_byte
//  result_out  | out | valid & ready                           | found, match_address
//  cfg_*       | in  | cfg_we                                  | cfg_index, cfg_data
//
//  One byte per cycle while scan_in.ready is high. A result is presented once its byte has passed
//  the window register, the compare/result register and the address add/output register.
//  Synchronous reset clears control state; configuration resets to zero, length to one.
//  scan_in.ready drops only when a result is due while both result registers are full.
module wildcard_byte_signature_scanner_core #(
  parameter int MAX_SIGNATURE = 16,
  parameter int WINDOW_BYTES  = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [wbss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wbss_pkg::CFG_DATA_W-1:0]  cfg_data,
  wbss_in_if.sink                          scan_in,
  wbss_out_if.source                       result_out
);
  import wbss_pkg::*;

  cfg_t             cfg;
  byte_t            window [WINDOW_BYTES];
  logic [POS_W-1:0] pos;
  logic             pending;
  logic             last_q;
  logic             scan_done;
  eval_ctl_t        ctl;
  logic             res_valid;
  res_t             res;
  logic             take;
  logic             accept;

  assign scan_in.ready = ~ctl.stall;
  assign accept        = scan_in.valid & scan_in.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sig_low   <= '0;
      cfg.sig_high  <= '0;
      cfg.wild_mask <= '0;
      cfg.sig_len   <= 5'd1;
      cfg.rel_size  <= '0;
      cfg.base_addr <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIG_LOW:   cfg.sig_low   <= cfg_data;
        REG_SIG_HIGH:  cfg.sig_high  <= cfg_data;
        REG_WILD_MASK: cfg.wild_mask <= cfg_data[15:0];
        REG_SIG_LEN:   cfg.sig_len   <= cfg_data[4:0];
        REG_REL_SIZE:  cfg.rel_size  <= cfg_data[5:0];
        REG_BASE_ADDR: cfg.base_addr <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte window and scan bookkeeping
  wbss_window #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .first    (scan_in.first_byte),
    .last     (scan_in.last_byte),
    .data     (scan_in.scan_byte),
    .ctl      (ctl),
    .window   (window),
    .pos      (pos),
    .pending  (pending),
    .last_q   (last_q),
    .scan_done(scan_done)
  );

  // alignment compare and result register
  wbss_match #(
    .MAX_SIGNATURE(MAX_SIGNATURE),
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_match (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .window   (window),
    .pos      (pos),
    .pending  (pending),
    .last_q   (last_q),
    .take     (take),
    .ctl      (ctl),
    .res_valid(res_valid),
    .res      (res)
  );

  // address resolution and output register
  wbss_resolve u_resolve (
    .clk       (clk),
    .rst       (rst),
    .base_addr (cfg.base_addr),
    .res_valid (res_valid),
    .res       (res),
    .take      (take),
    .result_out(result_out)
  );

  // back-pressure only ever comes from a byte waiting on its result
  a_stall_pending: assert property (@(posedge clk) disable iff (rst)
    !scan_in.ready |-> pending)
    else $error("input stalled with no byte under evaluation");

  // a delivered result closes the scan unless a new image starts alongside
  a_done_after_result: assert property (@(posedge clk) disable iff (rst)
    (ctl.emit && !ctl.stall && !(accept && scan_in.first_byte)) |=> scan_done)
    else $error("scan not closed after a result");

  // a waiting partial result holds while the output register is full
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !take) |=> (res_valid && $stable(res)))
    else $error("partial result lost under stall");

  // an accepted byte of an open scan advances the counter by one
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (accept && !scan_in.first_byte && !scan_done && !ctl.emit) |=> pos == $past(pos) + 32'd1)
    else $error("byte counter did not advance");

endmodule

>>> test/wildcard_byte_signature_scanner_core_test.sv
// wildcard_byte_signature_scanner_core_test: self-checking bench for the byte signature scanner
// depends on wbss_pkg, wbss_channels and the scanner core; predicts every result in-bench
module wildcard_byte_signature_scanner_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wbss_pkg::*;

  localparam int          SIG_MAX      = 16;
  localparam int          WIN          = 32;
  localparam int unsigned RANDOM_BYTES = 700;
  localparam int unsigned SETTLE       = 6;
  localparam int unsigned CYCLE_LIMIT  = 250000;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] address;
  } scan_outcome_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  wbss_in_if  scan_ch ();
  wbss_out_if res_ch ();

  wildcard_byte_signature_scanner_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .scan_in    (scan_ch),
    .result_out (res_ch)
  );

  // shadow of the configuration registers
  logic [63:0]       pat_low;
  logic [63:0]       pat_high;
  logic [15:0]       any_mask;
  logic [4:0]        pat_len;
  logic [5:0]        rel_size;
  logic [ADDR_W-1:0] base_addr;

  // shadow scan state, newest byte at entry 0
  byte_t       hist [WIN];
  logic [31:0] hist_count;
  bit          image_closed;

  scan_outcome_t outcomes_due [$];
  scan_outcome_t want;

  int unsigned bytes_taken     = 0;
  int unsigned bytes_ignored   = 0;
  int unsigned results_checked = 0;
  int unsigned fail_count      = 0;
  int unsigned settings_used   = 0;
  int unsigned burst_left      = 0;
  logic [31:0] cycle_count     = '0;
  bit          source_gaps     = 1'b1;
  bit          sink_stalls     = 1'b1;
  logic [15:0] stall_pattern   = 16'h5a5b;
  logic [31:0] stall_tick      = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic byte_t pattern_byte(int unsigned k);
    if (k < 8) return pat_low[8*k +: 8];
    if (k < 16) return pat_high[8*(k-8) +: 8];
    return 8'h00;
  endfunction

  function automatic int unsigned active_len();
    if (pat_len < 1) return 1;
    if (pat_len > SIG_MAX) return SIG_MAX;
    return int'(pat_len);
  endfunction

  function automatic int unsigned active_rel();
    if (rel_size < REL_MIN) return 0;
    if (rel_size > WIN) return WIN;
    return int'(rel_size);
  endfunction

  // byte at image offset q once n bytes are in; absent bytes read as zero
  function automatic byte_t image_at(longint unsigned n, longint unsigned q);
    longint unsigned d;
    if (q >= n) return 8'h00;
    d = n - 1 - q;
    if (d >= WIN) return 8'h00;
    return hist[d];
  endfunction

  function automatic bit aligned_hit(longint unsigned n, longint unsigned a, int unsigned len);
    for (int unsigned k = 0; k < len; k++) begin
      if (k < 16 && any_mask[k]) continue;
      if (image_at(n, a + k) != pattern_byte(k)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [63:0] resolve_target(longint unsigned n, longint unsigned a,
                                                 int unsigned rel);
    logic [63:0]     addr;
    logic [31:0]     disp;
    longint unsigned off;
    addr = base_addr + a;
    if (rel >= REL_MIN) begin
      off  = a + rel - 4;
      disp = {image_at(n, off + 3), image_at(n, off + 2), image_at(n, off + 1), image_at(n, off)};
      addr = addr + {{32{disp[31]}}, disp} + 64'(rel);
    end
    return addr;
  endfunction

  function automatic void restart_window();
    foreach (hist[i]) hist[i] = 8'h00;
    hist_count   = '0;
    image_closed = 1'b0;
  endfunction

  function automatic void record_outcome(bit hit, logic [63:0] addr);
    scan_outcome_t o;
    o.found   = hit;
    o.address = hit ? addr : '0;
    outcomes_due = {outcomes_due, o};
    image_closed = 1'b1;
  endfunction

  // returns 0 when the byte is ignored because the scan already finished
  function automatic bit scan_predict(byte_t b, bit first, bit last);
    longint unsigned n, a, lo;
    int unsigned     len, rel, span;
    if (first) restart_window();
    if (image_closed) return 1'b0;
    for (int i = WIN - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0]    = b;
    hist_count = hist_count + 1;
    n    = 64'(hist_count);
    len  = active_len();
    rel  = active_rel();
    span = (rel > len) ? rel : len;
    if (n >= span) begin
      a = n - span;
      if (aligned_hit(n, a, len)) begin
        record_outcome(1'b1, resolve_target(n, a, rel));
        return 1'b1;
      end
    end
    if (!last) return 1'b1;
    // end of image: remaining alignments that still fit, lowest first
    lo = (n >= span) ? n - span + 1 : 0;
    for (a = lo; a + len <= n; a++) begin
      if (aligned_hit(n, a, len)) begin
        record_outcome(1'b1, resolve_target(n, a, rel));
        return 1'b1;
      end
    end
    record_outcome(1'b0, '0);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- result checking

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_checked++;
      if (outcomes_due.size() == 0) begin
        $error("result with none due: found=%0b match_address=%h",
               res_ch.found, res_ch.match_address);
        fail_count++;
      end else begin
        want = outcomes_due.pop_front();
        if (res_ch.found !== want.found) begin
          $error("found: expected %0b, actual %0b", want.found, res_ch.found);
          fail_count++;
        end
        if (res_ch.match_address !== want.address) begin
          $error("match_address: expected %h, actual %h", want.address, res_ch.match_address);
          fail_count++;
        end
      end
    end
  end

  // result back-pressure on a rotating pattern, reloaded now and then
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (!sink_stalls) begin
      res_ch.ready <= 1'b1;
    end else begin
      res_ch.ready <= stall_pattern[stall_tick[3:0]];
    end
    if (stall_tick[5:0] == 6'd63) begin
      stall_pattern <= 16'($urandom) | 16'h0101;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[wildcard_byte_signature_scanner_core] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers

  // one byte transaction, with burst gaps in front when enabled
  task automatic send_byte(input byte_t b, input bit first, input bit last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (source_gaps) begin
        gap = $urandom_range(0, 5);
        if (gap != 0) begin
          scan_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    burst_left--;
    scan_ch.valid      <= 1'b1;
    scan_ch.scan_byte  <= b;
    scan_ch.first_byte <= first;
    scan_ch.last_byte  <= last;
    do @(posedge clk); while (!scan_ch.ready);
    if (scan_predict(b, first, last)) bytes_taken++;
    else bytes_ignored++;
  endtask

  // wait until every due result is out and the pipeline is empty
  task automatic settle();
    scan_ch.valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_SIG_LOW:   pat_low   = value;
      REG_SIG_HIGH:  pat_high  = value;
      REG_WILD_MASK: any_mask  = value[15:0];
      REG_SIG_LEN:   pat_len   = value[4:0];
      REG_REL_SIZE:  rel_size  = value[5:0];
      REG_BASE_ADDR: base_addr = value;
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [15:0] mask, input logic [4:0] len,
                              input logic [5:0] rel, input logic [63:0] base);
    settle();
    write_reg(REG_SIG_LOW, lo);
    write_reg(REG_SIG_HIGH, hi);
    write_reg(REG_WILD_MASK, 64'(mask));
    write_reg(REG_SIG_LEN, 64'(len));
    write_reg(REG_REL_SIZE, 64'(rel));
    write_reg(REG_BASE_ADDR, base);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // image of random bytes, biased towards signature bytes, optionally with a planted match
  task automatic send_image(input int unsigned n_bytes, input bit plant,
                            input bit flag_first, input bit flag_last);
    byte_t       img [];
    int unsigned used, at;
    img  = new[n_bytes];
    used = active_len();
    foreach (img[i]) begin
      img[i] = ($urandom_range(0, 2) == 0) ? pattern_byte($urandom_range(0, used - 1))
                                           : byte_t'($urandom);
    end
    if (plant && n_bytes >= used) begin
      at = $urandom_range(0, n_bytes - used);
      for (int unsigned k = 0; k < used; k++) begin
        if (!any_mask[k]) img[at + k] = pattern_byte(k);
      end
    end
    foreach (img[i]) begin
      send_byte(img[i], flag_first && i == 0, flag_last && i == int'(n_bytes) - 1);
    end
  endtask

  // ---------------------------------------------------------------- tests

  // reset values: one zero byte, no wildcards, plain address
  task automatic test_reset_values();
    send_byte(8'h12, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h34, 1'b0, 1'b1);  // after the match: ignored
    send_byte(8'haa, 1'b1, 1'b1);  // single-byte image, no match
  endtask

  // exact compare, address wrap at the top, all wildcards with a zero length
  task automatic test_plain_match();
    apply_config('1, '0, 16'h0000, 5'd2, 6'd0, '1);
    send_byte(8'hff, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b1);
    apply_config('0, '1, 16'hffff, 5'd0, 6'd1, 64'h8000_0000_0000_0000);
    send_byte(8'h00, 1'b1, 1'b0);
  endtask

  // displacement resolution: negative, clamped size, past the end, small size as none
  task automatic test_relative_targets();
    apply_config('0, '0, 16'hffff, 5'd4, 6'd4, 64'h100);
    send_byte(8'hfe, 1'b1, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    apply_config('0, '0, 16'hffff, 5'd1, 6'd63, '0);
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h02, 1'b0, 1'b0);
    send_byte(8'h03, 1'b0, 1'b1);
    // match only at the last alignment, found by the end-of-image pass
    apply_config(64'hc3a5, '0, 16'h0000, 5'd2, 6'd8, 64'h2000);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h11, 1'b0, 1'b0);
    send_byte(8'h22, 1'b0, 1'b0);
    send_byte(8'ha5, 1'b0, 1'b0);
    send_byte(8'hc3, 1'b0, 1'b1);
    apply_config(64'h5a, '0, 16'h0000, 5'd1, 6'd2, 64'h40);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h5a, 1'b0, 1'b0);
  endtask

  // image shorter than the signature
  task automatic test_short_image();
    apply_config({$urandom, $urandom}, '0, 16'h0000, 5'd5, 6'd0, '0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h7f, 1'b0, 1'b1);
  endtask

  // random settings, mostly well-formed images, some open or broken ones and noise
  task automatic test_random_images();
    int unsigned start_bytes, n_images, kind, n_bytes;
    logic [63:0] lo, hi, base;
    logic [15:0] mask;
    logic [4:0]  len;
    logic [5:0]  rel;
    start_bytes = bytes_taken + bytes_ignored;
    while (bytes_taken + bytes_ignored - start_bytes < RANDOM_BYTES) begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      case ($urandom_range(0, 7))
        0: mask = '0;
        1: mask = '1;
        default: mask = 16'($urandom & $urandom & $urandom);
      endcase
      case ($urandom_range(0, 9))
        0: len = 5'd0;
        1: len = 5'($urandom_range(17, 31));
        2: len = 5'd16;
        default: len = 5'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 9))
        0, 1: rel = 6'd0;
        2: rel = 6'($urandom_range(1, 3));
        3: rel = 6'($urandom_range(33, 63));
        4: rel = 6'd32;
        default: rel = 6'($urandom_range(4, 31));
      endcase
      case ($urandom_range(0, 7))
        0: base = '1;
        1: base = '0;
        default: base = {$urandom, $urandom};
      endcase
      apply_config(lo, hi, mask, len, rel, base);
      source_gaps = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      n_images = $urandom_range(2, 6);
      repeat (n_images) begin
        n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 80) : $urandom_range(1, 36);
        kind    = $urandom_range(0, 11);
        if (kind < 8) begin
          send_image(n_bytes, kind < 6, 1'b1, 1'b1);
        end else if (kind == 8) begin
          send_image(n_bytes, 1'b1, 1'b1, 1'b0);  // left open
        end else if (kind == 9) begin
          send_image(n_bytes, 1'b1, 1'b0, 1'b1);  // no start marker
        end else begin
          repeat ($urandom_range(1, 8)) begin
            send_byte(byte_t'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = REG_SIG_LOW;
    cfg_data           = '0;
    scan_ch.valid      = 1'b0;
    scan_ch.scan_byte  = 8'h00;
    scan_ch.first_byte = 1'b0;
    scan_ch.last_byte  = 1'b0;
    pat_low            = '0;
    pat_high           = '0;
    any_mask           = '0;
    pat_len            = 5'd1;
    rel_size           = '0;
    base_addr          = '0;
    restart_window();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_plain_match();
    test_relative_targets();
    test_short_image();
    test_random_images();

    settle();
    repeat (10) @(posedge clk);
    $display("scanned %0d bytes (%0d ignored after a finished scan) under %0d settings",
             bytes_taken, bytes_ignored, settings_used);
    $display("checked %0d results, %0d mismatches", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("[wildcard_byte_signature_scanner_core] OK");
    end else begin
      $display("[wildcard_byte_signature_scanner_core] ERROR");
    end
    $finish;
  end

endmodule
